[src/qbv_pkg.sv]
// ----------------------------------------------------------------------------
// qbv_pkg: shared constants and types
// Fixed-point widths, pipeline depths and register codes of the
// vector-to-vector rotation quaternion block.
// ----------------------------------------------------------------------------
package qbv_pkg;

  // Q1.14 unit
  localparam int QONE       = 16384;

  // configuration port
  localparam int REG_W      = 15;
  localparam int CFG_ADDR_W = 2;

  // square root: 60-bit radicand, 30 root bits, one bit per stage
  localparam int SQRT_BITS  = 30;
  localparam int SQRT_IN_W  = 2 * SQRT_BITS;
  localparam int SQRT_LAT   = SQRT_BITS;

  // divider: 44-bit numerator, 30-bit divisor, 15 quotient bits
  localparam int DIV_NUM_W  = 44;
  localparam int DIV_DEN_W  = 30;
  localparam int DIV_Q_BITS = 15;
  localparam int DIV_LAT    = DIV_Q_BITS + 2;

  // full pipeline: two root pipelines in series, two divider banks, eleven single stages
  localparam int PIPE_LEN   = 2 * SQRT_LAT + 2 * DIV_LAT + 11;

  typedef logic [REG_W-1:0]      reg_t;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  typedef logic signed [15:0]    s16_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_OPP_MARGIN = 2'd0,
    CFG_AXIS_MIN   = 2'd1
  } cfg_reg_t;

  localparam reg_t OPP_MARGIN_RST = 15'd16;
  localparam reg_t AXIS_MIN_RST   = 15'd164;

endpackage

[src/qbv_in_if.sv]
// ----------------------------------------------------------------------------
// qbv_in_if: input vector pair channel
// Valid/ready channel carrying the start and destination vectors.
// ----------------------------------------------------------------------------
interface qbv_in_if import qbv_pkg::*; ();
  logic valid;
  logic ready;
  s16_t start_x;
  s16_t start_y;
  s16_t start_z;
  s16_t dest_x;
  s16_t dest_y;
  s16_t dest_z;

  modport source (output valid, start_x, start_y, start_z, dest_x, dest_y, dest_z,
                  input ready);
  modport sink   (input valid, start_x, start_y, start_z, dest_x, dest_y, dest_z,
                  output ready);
endinterface

[src/qbv_out_if.sv]
// ----------------------------------------------------------------------------
// qbv_out_if: quaternion result channel
// Valid/ready channel carrying the Q1.14 quaternion and the case flags.
// ----------------------------------------------------------------------------
interface qbv_out_if import qbv_pkg::*; ();
  logic valid;
  logic ready;
  s16_t quat_w;
  s16_t quat_x;
  s16_t quat_y;
  s16_t quat_z;
  logic opposite_case;
  logic zero_vector;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, opposite_case,
                  zero_vector, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, opposite_case,
                  zero_vector, output ready);
endinterface

[src/qbv_cfg_if.sv]
// ----------------------------------------------------------------------------
// qbv_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface qbv_cfg_if import qbv_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_addr_t addr;
  reg_t      data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

[src/qbv_isqrt.sv]
// ----------------------------------------------------------------------------
// qbv_isqrt: pipelined integer square root
// floor(sqrt(rad)), one root bit resolved per register stage.
// ----------------------------------------------------------------------------
module qbv_isqrt import qbv_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [SQRT_IN_W-1:0] rad,
  output logic [SQRT_BITS-1:0] root
);

  logic [SQRT_IN_W-1:0] rem_r  [SQRT_BITS-1];
  logic [SQRT_BITS-1:0] root_r [SQRT_BITS];

  for (genvar k = 0; k < SQRT_BITS; k++) begin : g_step
    localparam int B = SQRT_BITS - 1 - k;
    logic [SQRT_IN_W-1:0] rem_in;
    logic [SQRT_BITS-1:0] root_in;
    logic [SQRT_IN_W:0]   trial;
    logic                 take;

    if (k == 0) begin : g_first
      assign rem_in  = rad;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    // (2*root + 2^B) * 2^B
    assign trial = ((SQRT_IN_W+1)'(root_in) << (B + 1)) | ((SQRT_IN_W+1)'(1) << (2 * B));
    assign take  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= take ? (root_in | (SQRT_BITS'(1) << B)) : root_in;
      end
    end

    if (k < SQRT_BITS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? SQRT_IN_W'({1'b0, rem_in} - trial) : rem_in;
        end
      end
    end
  end

  assign root = root_r[SQRT_BITS-1];

endmodule

[src/qbv_div.sv]
// ----------------------------------------------------------------------------
// qbv_div: pipelined rounding divider
// Restoring division of a pre-rounded magnitude, one quotient bit per stage,
// then sign and saturation to the Q1.14 unit range.
// ----------------------------------------------------------------------------
module qbv_div import qbv_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  input  logic                 neg,
  output s16_t                 quo
);

  localparam int RW = DIV_NUM_W + 1;

  logic [DIV_NUM_W-1:0]  rem_r [DIV_Q_BITS];
  logic [DIV_DEN_W-1:0]  den_r [DIV_Q_BITS];
  logic [DIV_Q_BITS-1:0] q_r   [DIV_Q_BITS+1];
  logic                  neg_r [DIV_Q_BITS+1];
  logic                  ovf_r [DIV_Q_BITS+1];
  logic [DIV_Q_BITS-1:0] mag;
  s16_t                  quo_r;

  // overflow check: quotient would need more than DIV_Q_BITS bits
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0] <= {1'b0, num} >= RW'({den, {DIV_Q_BITS{1'b0}}});
      rem_r[0] <= num;
      den_r[0] <= den;
      neg_r[0] <= neg;
      q_r[0]   <= '0;
    end
  end

  for (genvar j = 1; j <= DIV_Q_BITS; j++) begin : g_bit
    localparam int B = DIV_Q_BITS - j;
    logic [RW-1:0] trial;
    logic          take;

    assign trial = RW'(den_r[j-1]) << B;
    assign take  = {1'b0, rem_r[j-1]} >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j]   <= take ? (q_r[j-1] | (DIV_Q_BITS'(1) << B)) : q_r[j-1];
        neg_r[j] <= neg_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
      end
    end

    if (j < DIV_Q_BITS) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= take ? DIV_NUM_W'({1'b0, rem_r[j-1]} - trial) : rem_r[j-1];
          den_r[j] <= den_r[j-1];
        end
      end
    end
  end

  // saturate and apply sign
  always_comb begin
    if (ovf_r[DIV_Q_BITS] || (q_r[DIV_Q_BITS] > DIV_Q_BITS'(QONE))) begin
      mag = DIV_Q_BITS'(QONE);
    end else begin
      mag = q_r[DIV_Q_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= neg_r[DIV_Q_BITS] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign quo = quo_r;

endmodule

[src/quaternion_between_vectors.sv]
// ----------------------------------------------------------------------------
// quaternion_between_vectors: rotation quaternion between two 3D vectors
// Normalizes both vectors to Q1.14, takes their cosine and cross product and
// forms the unit quaternion, with a half-turn path for opposite vectors.
//
//   channel  dir  handshake       contents
//   in_ch    in   valid / ready   start_x/y/z, dest_x/y/z (signed 16)
//   out_ch   out  valid / ready   quat_w/x/y/z (Q1.14), opposite_case, zero_vector
//   cfg_ch   in   valid / ready   addr (register index), data (15 bits)
//
// One vector pair per cycle while no result waits untaken at the output; each
// pair passes two 30-stage square-root pipelines and two 17-stage divider
// banks. Reset clears the valid line and loads the register defaults.
// A result held in the output register and not taken stalls every stage
// together, so nothing is dropped or repeated; cfg_ch is always ready.
// ----------------------------------------------------------------------------
module quaternion_between_vectors import qbv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  qbv_in_if.sink    in_ch,
  qbv_out_if.source out_ch,
  qbv_cfg_if.sink   cfg_ch
);

  typedef struct packed {
    logic [2:0][15:0] a;
    logic [2:0][15:0] b;
    logic             zero;
  } side1_t;

  typedef struct packed {
    logic             opp;
    logic             zero;
    logic [2:0][15:0] ax;
    logic [2:0][30:0] cr;
  } side3_t;

  typedef struct packed {
    logic [14:0] w;
    logic        opp;
    logic        zero;
    logic        sz;
  } side4_t;

  logic                en;
  logic [PIPE_LEN-1:0] vld_r;

  // ---------------- configuration registers ----------------
  reg_t        margin_r;
  reg_t        aml_r;
  logic [29:0] aml_sq_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= OPP_MARGIN_RST;
      aml_r    <= AXIS_MIN_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        CFG_OPP_MARGIN: margin_r <= cfg_ch.data;
        CFG_AXIS_MIN:   aml_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    aml_sq_r <= 30'(32'(aml_r) * 32'(aml_r));
  end

  // ---------------- valid line and global stall ----------------
  assign en          = !vld_r[PIPE_LEN-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LEN-2:0], in_ch.valid};
    end
  end

  // ---------------- stage 1: squares ----------------
  s16_t        in_a [3];
  s16_t        in_b [3];
  s16_t        a1_r [3];
  s16_t        b1_r [3];
  logic [30:0] sqa1_r [3];
  logic [30:0] sqb1_r [3];

  assign in_a[0] = in_ch.start_x;
  assign in_a[1] = in_ch.start_y;
  assign in_a[2] = in_ch.start_z;
  assign in_b[0] = in_ch.dest_x;
  assign in_b[1] = in_ch.dest_y;
  assign in_b[2] = in_ch.dest_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a1_r[i]   <= in_a[i];
        b1_r[i]   <= in_b[i];
        sqa1_r[i] <= 31'(32'(in_a[i]) * 32'(in_a[i]));
        sqb1_r[i] <= 31'(32'(in_b[i]) * 32'(in_b[i]));
      end
    end
  end

  // ---------------- stage 2: squared lengths ----------------
  logic [31:0]      l2a_nxt, l2b_nxt;
  logic [31:0]      l2a_r, l2b_r;
  logic [2:0][15:0] a2_r, b2_r;
  logic             zero2_r;

  assign l2a_nxt = 32'(sqa1_r[0]) + 32'(sqa1_r[1]) + 32'(sqa1_r[2]);
  assign l2b_nxt = 32'(sqb1_r[0]) + 32'(sqb1_r[1]) + 32'(sqb1_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a2_r[i] <= a1_r[i];
        b2_r[i] <= b1_r[i];
      end
      l2a_r   <= l2a_nxt;
      l2b_r   <= l2b_nxt;
      zero2_r <= (l2a_nxt == '0) || (l2b_nxt == '0);
    end
  end

  // ---------------- vector lengths ----------------
  logic [SQRT_BITS-1:0] ra, rb;
  side1_t               side1_r [SQRT_LAT];
  side1_t               s1;

  qbv_isqrt u_sqrt_a (.clk(clk), .en(en), .rad({l2a_r, 28'd0}), .root(ra));
  qbv_isqrt u_sqrt_b (.clk(clk), .en(en), .rad({l2b_r, 28'd0}), .root(rb));

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r[0] <= '{a: a2_r, b: b2_r, zero: zero2_r};
      for (int k = 1; k < SQRT_LAT; k++) begin
        side1_r[k] <= side1_r[k-1];
      end
    end
  end

  assign s1 = side1_r[SQRT_LAT-1];

  // ---------------- stage 4: normalize numerators ----------------
  s16_t                 v4 [6];
  logic [15:0]          vmag4 [6];
  logic [DIV_NUM_W-1:0] num4_r [6];
  logic                 neg4_r [6];
  logic [SQRT_BITS-1:0] ra4_r, rb4_r;
  logic                 zero4_r;

  assign v4[0] = $signed(s1.a[0]);
  assign v4[1] = $signed(s1.a[1]);
  assign v4[2] = $signed(s1.a[2]);
  assign v4[3] = $signed(s1.b[0]);
  assign v4[4] = $signed(s1.b[1]);
  assign v4[5] = $signed(s1.b[2]);

  for (genvar i = 0; i < 6; i++) begin : g_vmag
    assign vmag4[i] = v4[i][15] ? 16'(-v4[i]) : 16'(v4[i]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        num4_r[i] <= {vmag4[i], 28'd0} + DIV_NUM_W'((i < 3 ? ra : rb) >> 1);
        neg4_r[i] <= v4[i][15];
      end
      ra4_r   <= ra;
      rb4_r   <= rb;
      zero4_r <= s1.zero;
    end
  end

  // ---------------- unit vectors ----------------
  s16_t nq [6];
  logic side2_r [DIV_LAT];

  for (genvar i = 0; i < 6; i++) begin : g_ndiv
    qbv_div u_div (
      .clk(clk), .en(en), .num(num4_r[i]),
      .den((i < 3) ? ra4_r : rb4_r), .neg(neg4_r[i]), .quo(nq[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2_r[0] <= zero4_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        side2_r[k] <= side2_r[k-1];
      end
    end
  end

  // ---------------- stage 6: dot, cross and axis products ----------------
  logic signed [29:0] dp6_r [3];
  logic signed [29:0] pa6_r [3];
  logic signed [29:0] pb6_r [3];
  logic [28:0]        sq06_r, sq16_r;
  s16_t               sn6_r [3];
  logic               zero6_r;

  // nq[0..2] is the start unit vector, nq[3..5] the destination
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dp6_r[i] <= 30'(32'(nq[i]) * 32'(nq[3+i]));
        sn6_r[i] <= nq[i];
      end
      pa6_r[0] <= 30'(32'(nq[1]) * 32'(nq[5]));
      pb6_r[0] <= 30'(32'(nq[2]) * 32'(nq[4]));
      pa6_r[1] <= 30'(32'(nq[2]) * 32'(nq[3]));
      pb6_r[1] <= 30'(32'(nq[0]) * 32'(nq[5]));
      pa6_r[2] <= 30'(32'(nq[0]) * 32'(nq[4]));
      pb6_r[2] <= 30'(32'(nq[1]) * 32'(nq[3]));
      sq06_r   <= 29'(32'(nq[0]) * 32'(nq[0]));
      sq16_r   <= 29'(32'(nq[1]) * 32'(nq[1]));
      zero6_r  <= side2_r[DIV_LAT-1];
    end
  end

  // ---------------- stage 7: sums ----------------
  logic signed [30:0] dot7_r;
  logic signed [30:0] cr7_r [3];
  logic               usex7_r;
  s16_t               sn7_r [3];
  logic               zero7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dot7_r <= 31'(dp6_r[0]) + 31'(dp6_r[1]) + 31'(dp6_r[2]);
      for (int i = 0; i < 3; i++) begin
        cr7_r[i] <= 31'(pa6_r[i]) - 31'(pb6_r[i]);
        sn7_r[i] <= sn6_r[i];
      end
      // Z-cross axis too short: fall back to the X cross
      usex7_r <= (30'(sq06_r) + 30'(sq16_r)) < aml_sq_r;
      zero7_r <= zero6_r;
    end
  end

  // ---------------- stage 8: cosine rounding ----------------
  logic [30:0]        dmag8;
  logic [16:0]        drq8;
  logic [14:0]        dsat8;
  s16_t               cos8_r;
  logic signed [30:0] cr8_r [3];
  logic               usex8_r;
  s16_t               sn8_r [3];
  logic               zero8_r;

  assign dmag8 = dot7_r[30] ? 31'(-dot7_r) : 31'(dot7_r);
  assign drq8  = 17'((dmag8 + 31'd8192) >> 14);
  assign dsat8 = (drq8 > 17'(QONE)) ? 15'(QONE) : 15'(drq8);

  always_ff @(posedge clk) begin
    if (en) begin
      cos8_r  <= dot7_r[30] ? -$signed({1'b0, dsat8}) : $signed({1'b0, dsat8});
      cr8_r   <= cr7_r;
      sn8_r   <= sn7_r;
      usex8_r <= usex7_r;
      zero8_r <= zero7_r;
    end
  end

  // ---------------- stage 9: case decision and axis guess ----------------
  logic [15:0]        c1_9_nxt;
  logic [15:0]        c1_9_r;
  logic               opp9_r;
  s16_t               ax9_r [3];
  logic signed [30:0] cr9_r [3];
  logic               zero9_r;

  // 1 + cos in Q1.14, 0 .. 32768
  assign c1_9_nxt = 16'(cos8_r) + 16'(QONE);

  always_ff @(posedge clk) begin
    if (en) begin
      c1_9_r  <= c1_9_nxt;
      opp9_r  <= !zero8_r && (c1_9_nxt < {1'b0, margin_r});
      if (usex8_r) begin
        ax9_r[0] <= '0;
        ax9_r[1] <= -sn8_r[2];
        ax9_r[2] <= sn8_r[1];
      end else begin
        ax9_r[0] <= -sn8_r[1];
        ax9_r[1] <= sn8_r[0];
        ax9_r[2] <= '0;
      end
      cr9_r   <= cr8_r;
      zero9_r <= zero8_r;
    end
  end

  // ---------------- stage 10: axis squares ----------------
  logic [28:0]        axsq10_r [3];
  logic [15:0]        c1_10_r;
  logic               opp10_r;
  s16_t               ax10_r [3];
  logic signed [30:0] cr10_r [3];
  logic               zero10_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        axsq10_r[i] <= 29'(32'(ax9_r[i]) * 32'(ax9_r[i]));
      end
      c1_10_r  <= c1_9_r;
      opp10_r  <= opp9_r;
      ax10_r   <= ax9_r;
      cr10_r   <= cr9_r;
      zero10_r <= zero9_r;
    end
  end

  // ---------------- stage 11: shared root radicand ----------------
  logic [29:0]          l2ax11;
  logic [SQRT_IN_W-1:0] rad11_r;
  side3_t               s3_in_r;

  assign l2ax11 = 30'(axsq10_r[0]) + 30'(axsq10_r[1]) + 30'(axsq10_r[2]);

  // half-turn: axis length; otherwise s = sqrt(2(1 + cos)) in Q28
  always_ff @(posedge clk) begin
    if (en) begin
      rad11_r <= opp10_r ? {2'd0, l2ax11, 28'd0} : {1'b0, c1_10_r, 43'd0};
      s3_in_r.opp  <= opp10_r;
      s3_in_r.zero <= zero10_r;
      for (int i = 0; i < 3; i++) begin
        s3_in_r.ax[i] <= ax10_r[i];
        s3_in_r.cr[i] <= cr10_r[i];
      end
    end
  end

  logic [SQRT_BITS-1:0] sroot;
  side3_t               side3_r [SQRT_LAT];
  side3_t               s3;

  qbv_isqrt u_sqrt_s (.clk(clk), .en(en), .rad(rad11_r), .root(sroot));

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r[0] <= s3_in_r;
      for (int k = 1; k < SQRT_LAT; k++) begin
        side3_r[k] <= side3_r[k-1];
      end
    end
  end

  assign s3 = side3_r[SQRT_LAT-1];

  // ---------------- stage 12: quaternion numerators ----------------
  s16_t                 ax12 [3];
  logic signed [30:0]   cr12 [3];
  logic [14:0]          axmag12 [3];
  logic [29:0]          crmag12 [3];
  logic [DIV_NUM_W-1:0] num12_r [3];
  logic                 neg12_r [3];
  logic [SQRT_BITS-1:0] den12_r;
  side4_t               s4_in_r;

  for (genvar i = 0; i < 3; i++) begin : g_qmag
    assign ax12[i]    = $signed(s3.ax[i]);
    assign cr12[i]    = $signed(s3.cr[i]);
    assign axmag12[i] = ax12[i][15] ? 15'(-ax12[i]) : 15'(ax12[i]);
    assign crmag12[i] = cr12[i][30] ? 30'(-cr12[i]) : 30'(cr12[i]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (s3.opp) begin
          // negated unit axis
          num12_r[i] <= {1'b0, axmag12[i], 28'd0} + DIV_NUM_W'(sroot >> 1);
          neg12_r[i] <= !ax12[i][15];
        end else begin
          num12_r[i] <= {crmag12[i], 14'd0} + DIV_NUM_W'(sroot >> 1);
          neg12_r[i] <= cr12[i][30];
        end
      end
      den12_r      <= sroot;
      s4_in_r.w    <= s3.opp ? 15'd0 : 15'((31'(sroot) + 31'(QONE)) >> 15);
      s4_in_r.opp  <= s3.opp;
      s4_in_r.zero <= s3.zero;
      s4_in_r.sz   <= (sroot == '0);
    end
  end

  // ---------------- quaternion vector part ----------------
  s16_t   qv [3];
  side4_t side4_r [DIV_LAT];
  side4_t s4;

  for (genvar i = 0; i < 3; i++) begin : g_qdiv
    qbv_div u_div (
      .clk(clk), .en(en), .num(num12_r[i]), .den(den12_r), .neg(neg12_r[i]), .quo(qv[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4_r[0] <= s4_in_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        side4_r[k] <= side4_r[k-1];
      end
    end
  end

  assign s4 = side4_r[DIV_LAT-1];

  // ---------------- output register ----------------
  s16_t qw_r, qx_r, qy_r, qz_r;
  logic opp_r, zero_r;

  // zero-length input or zero root: all-zero quaternion
  always_ff @(posedge clk) begin
    if (en) begin
      qw_r   <= s4.zero ? '0 : $signed({1'b0, s4.w});
      qx_r   <= (s4.zero || s4.sz) ? '0 : qv[0];
      qy_r   <= (s4.zero || s4.sz) ? '0 : qv[1];
      qz_r   <= (s4.zero || s4.sz) ? '0 : qv[2];
      opp_r  <= s4.opp;
      zero_r <= s4.zero;
    end
  end

  assign out_ch.valid         = vld_r[PIPE_LEN-1];
  assign out_ch.quat_w        = qw_r;
  assign out_ch.quat_x        = qx_r;
  assign out_ch.quat_y        = qy_r;
  assign out_ch.quat_z        = qz_r;
  assign out_ch.opposite_case = opp_r;
  assign out_ch.zero_vector   = zero_r;

endmodule
